[src/owner_tagged_timer_bank_assert.svh]
// Assertion macros used by the timer bank checker.
`ifndef OWNER_TAGGED_TIMER_BANK_ASSERT_SVH
`define OWNER_TAGGED_TIMER_BANK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OTTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OTTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ottb_pkg.sv]
// Shared constants, types and helpers of the owner-tagged timer bank.
package ottb_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    localparam logic [2:0] ACT_CREATE       = 3'd0;
    localparam logic [2:0] ACT_CANCEL_ID    = 3'd1;
    localparam logic [2:0] ACT_CANCEL_OWNER = 3'd2;
    localparam logic [2:0] ACT_TICK_OWNER   = 3'd3;
    localparam logic [2:0] ACT_CLEAR_ALL    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [7:0]  owner;
        logic [15:0] remaining;
        logic [15:0] reload;
        logic        periodic;
        logic [31:0] id;
        logic [15:0] tag;
    } t_entry;

    // one write port into the slot table
    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic              we_valid;
        logic              valid;
        logic              we_entry;
        logic              we_rem;
        t_entry            entry;
        logic [15:0]       rem;
    } t_slot_wr;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [31:0] result_id;
        logic [15:0] result_tag;
        logic        fired;
        logic [4:0]  removed_count;
        logic        last_result;
    } t_result;

    function automatic logic [4:0] sat_removed(input logic [CNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        if (wide > 32'd31) begin
            return 5'd31;
        end
        return wide[4:0];
    endfunction

endpackage

[src/ottb_if.sv]
// Command and result channel interfaces of the timer bank.
interface ottb_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  owner_tag;
    logic [15:0] frames;
    logic [15:0] reload_interval;
    logic        is_periodic;
    logic [15:0] callback_tag;
    logic [31:0] timer_id;

    modport source (
        output valid, action, owner_tag, frames, reload_interval, is_periodic,
               callback_tag, timer_id,
        input  ready
    );
    modport sink (
        input  valid, action, owner_tag, frames, reload_interval, is_periodic,
               callback_tag, timer_id,
        output ready
    );
endinterface

interface ottb_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_status;
    logic [31:0] result_id;
    logic [15:0] result_tag;
    logic        fired;
    logic [4:0]  removed_count;
    logic        last_result;

    modport source (
        output valid, result_status, result_id, result_tag, fired, removed_count,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, result_status, result_id, result_tag, fired, removed_count,
               last_result,
        output ready
    );
endinterface

[src/ottb_cmp_unit.sv]
// Shared 32-bit id comparator used by the scan and the min-id search.
module ottb_cmp_unit (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_eq,
    output logic        o_lt
);
    assign o_eq = (i_a == i_b);
    assign o_lt = (i_a < i_b);
endmodule

[src/ottb_slot_table.sv]
// Timer slot storage: valid flags plus entry fields, one read and one write port.
module ottb_slot_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ottb_pkg::SLOT_W-1:0]    i_rd_idx,
    output logic                           o_rd_valid,
    output ottb_pkg::t_entry               o_rd_entry,
    input  ottb_pkg::t_slot_wr             i_wr
);
    logic [ottb_pkg::SLOTS-1:0] r_valid;
    ottb_pkg::t_entry           r_entry [ottb_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we_valid) begin
            r_valid[i_wr.idx] <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_entry) begin
            r_entry[i_wr.idx] <= i_wr.entry;
        end else if (i_wr.we_rem) begin
            r_entry[i_wr.idx].remaining <= i_wr.rem;
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_entry = r_entry[i_rd_idx];
endmodule

[src/owner_tagged_timer_bank.sv]
// Owner-tagged countdown timer bank: a sequencer walks the slot table one slot per cycle.
// Every command runs a full scan (S_SCAN) and a finish state (S_FIN); the result goes to
// the output register in S_EMIT, and the next command is taken back in S_IDLE.
// A tick with expiries then runs a min-id search over all slots (S_SORT), a pop (S_POP)
// and S_EMIT for each expiry, in ascending id order; output stalls hold S_EMIT.
// Synchronous active-low reset empties the table, zeroes the id counter, drops results.
module owner_tagged_timer_bank (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ottb_cmd_if.sink   i_cmd,
    ottb_res_if.source o_res
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_SORT,
        S_POP,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [2:0]                   r_act;
    logic [7:0]                   r_owner;
    logic [15:0]                  r_frames;
    logic [15:0]                  r_reload;
    logic                         r_periodic;
    logic [15:0]                  r_tag;
    logic [31:0]                  r_key;
    logic [31:0]                  r_counter;
    logic [ottb_pkg::SLOT_W-1:0]  r_idx;
    logic                         r_hit;
    logic [ottb_pkg::SLOT_W-1:0]  r_hit_idx;
    logic                         r_free;
    logic [ottb_pkg::SLOT_W-1:0]  r_free_idx;
    logic [15:0]                  r_cap_tag;
    logic [ottb_pkg::CNT_W-1:0]   r_cnt;
    logic [ottb_pkg::SLOTS-1:0]   r_exp;
    logic                         r_best_ok;
    logic [ottb_pkg::SLOT_W-1:0]  r_best_idx;
    ottb_pkg::t_entry             r_best;
    ottb_pkg::t_result            r_res;
    ottb_pkg::t_result            r_out;
    logic                         r_out_valid;

    ottb_pkg::t_result            n_res;
    logic                         n_out_valid;

    logic                         rd_valid;
    ottb_pkg::t_entry             rd_entry;
    ottb_pkg::t_slot_wr           wr;
    logic [31:0]                  cmp_b;
    logic                         cmp_eq;
    logic                         cmp_lt;
    logic [15:0]                  dec_rem;
    logic                         owner_match;

    ottb_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry),
        .i_wr       (wr)
    );

    ottb_cmp_unit u_cmp (
        .i_a  (rd_entry.id),
        .i_b  (cmp_b),
        .o_eq (cmp_eq),
        .o_lt (cmp_lt)
    );

    assign cmp_b       = (r_state == S_SORT) ? r_best.id : r_key;
    assign dec_rem     = (rd_entry.remaining == 16'd0) ? 16'd0 : rd_entry.remaining - 16'd1;
    assign owner_match = rd_valid && (rd_entry.owner == r_owner);

    always_comb begin
        wr                = '0;
        wr.idx            = r_idx;
        wr.entry.owner    = r_owner;
        wr.entry.remaining = r_frames;
        wr.entry.reload   = r_reload;
        wr.entry.periodic = r_periodic;
        wr.entry.id       = r_key;
        wr.entry.tag      = r_tag;
        wr.rem            = dec_rem;
        case (r_state)
            S_SCAN: begin
                case (r_act)
                    ottb_pkg::ACT_CANCEL_ID: begin
                        if (rd_valid && cmp_eq && !r_hit) begin
                            wr.we_valid = 1'b1;
                        end
                    end
                    ottb_pkg::ACT_CANCEL_OWNER: begin
                        wr.we_valid = owner_match;
                    end
                    ottb_pkg::ACT_CLEAR_ALL: begin
                        wr.we_valid = rd_valid;
                    end
                    ottb_pkg::ACT_TICK_OWNER: begin
                        wr.we_rem = owner_match;
                    end
                    default: ;
                endcase
            end
            S_FIN: begin
                if (r_act == ottb_pkg::ACT_CREATE && (r_hit || r_free)) begin
                    wr.idx      = r_hit ? r_hit_idx : r_free_idx;
                    wr.we_valid = 1'b1;
                    wr.valid    = 1'b1;
                    wr.we_entry = 1'b1;
                end
            end
            S_POP: begin
                wr.idx = r_best_idx;
                if (r_best.periodic) begin
                    wr.we_rem = 1'b1;
                    wr.rem    = r_best.reload;
                end else begin
                    wr.we_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result built at the end of a scan or for one expiry
    always_comb begin
        n_res             = '0;
        n_res.last_result = 1'b1;
        case (r_state)
            S_FIN: begin
                case (r_act)
                    ottb_pkg::ACT_CREATE: begin
                        if (r_hit || r_free) begin
                            n_res.result_status = ottb_pkg::ST_OK;
                            n_res.result_id     = r_key;
                        end else begin
                            n_res.result_status = ottb_pkg::ST_FULL;
                        end
                    end
                    ottb_pkg::ACT_CANCEL_ID: begin
                        n_res.result_status = r_hit ? ottb_pkg::ST_OK : ottb_pkg::ST_NOT_FOUND;
                        n_res.result_id     = r_key;
                        n_res.result_tag    = r_hit ? r_cap_tag : 16'd0;
                    end
                    ottb_pkg::ACT_CANCEL_OWNER, ottb_pkg::ACT_CLEAR_ALL: begin
                        n_res.removed_count = ottb_pkg::sat_removed(r_cnt);
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                n_res.result_status = ottb_pkg::ST_OK;
                n_res.result_id     = r_best.id;
                n_res.result_tag    = r_best.tag;
                n_res.fired         = 1'b1;
                n_res.last_result   = (r_cnt == ottb_pkg::CNT_W'(1));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        if (r_state == S_EMIT && (!r_out_valid || o_res.ready)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            r_exp       <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_best_ok   <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_act      <= i_cmd.action;
                        r_owner    <= i_cmd.owner_tag;
                        r_frames   <= i_cmd.frames;
                        r_reload   <= i_cmd.reload_interval;
                        r_periodic <= i_cmd.is_periodic;
                        r_tag      <= i_cmd.callback_tag;
                        r_key      <= (i_cmd.action == ottb_pkg::ACT_CREATE) ?
                                      r_counter + 32'd1 : i_cmd.timer_id;
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_cnt      <= '0;
                        r_exp      <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    case (r_act)
                        ottb_pkg::ACT_CREATE: begin
                            if (rd_valid && cmp_eq && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_idx;
                            end
                            if (!rd_valid && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_idx;
                            end
                        end
                        ottb_pkg::ACT_CANCEL_ID: begin
                            if (rd_valid && cmp_eq && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_cap_tag <= rd_entry.tag;
                            end
                        end
                        ottb_pkg::ACT_CANCEL_OWNER: begin
                            if (owner_match) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                        ottb_pkg::ACT_CLEAR_ALL: begin
                            if (rd_valid) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                        ottb_pkg::ACT_TICK_OWNER: begin
                            // expired count doubles as the number of results to deliver
                            if (owner_match && dec_rem == 16'd0) begin
                                r_exp[r_idx] <= 1'b1;
                                r_cnt        <= r_cnt + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (r_idx == ottb_pkg::LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    r_res <= n_res;
                    if (r_act == ottb_pkg::ACT_CREATE && (r_hit || r_free)) begin
                        r_counter <= r_key;
                    end
                    if (r_act == ottb_pkg::ACT_TICK_OWNER && r_cnt != '0) begin
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_state   <= S_SORT;
                    end else begin
                        r_state   <= S_EMIT;
                    end
                end
                S_SORT: begin
                    // ids are unique in the table, so a strict compare finds the minimum
                    if (r_exp[r_idx] && (!r_best_ok || cmp_lt)) begin
                        r_best_ok  <= 1'b1;
                        r_best_idx <= r_idx;
                        r_best     <= rd_entry;
                    end
                    if (r_idx == ottb_pkg::LAST_IDX) begin
                        r_state <= S_POP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POP: begin
                    r_exp[r_best_idx] <= 1'b0;
                    r_res             <= n_res;
                    r_cnt             <= r_cnt - 1'b1;
                    r_state           <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out <= r_res;
                        if (r_res.last_result) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx     <= '0;
                            r_best_ok <= 1'b0;
                            r_state   <= S_SORT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.result_status = r_out.result_status;
    assign o_res.result_id     = r_out.result_id;
    assign o_res.result_tag    = r_out.result_tag;
    assign o_res.fired         = r_out.fired;
    assign o_res.removed_count = r_out.removed_count;
    assign o_res.last_result   = r_out.last_result;
endmodule

[src/ottb_checker.sv]
// Port-level checker for the timer bank, bound to the top level.
`include "owner_tagged_timer_bank_assert.svh"

module ottb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_res_status,
    input logic [31:0] i_res_id,
    input logic [15:0] i_res_tag,
    input logic        i_res_fired,
    input logic [4:0]  i_res_removed,
    input logic        i_res_last
);
    // ready is low in the cycle after a command is taken, as the sequencer is then busy
    `OTTB_ASSERT_NEXT(a_cmd_busy, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "ready after transfer")

    `OTTB_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_status) && $stable(i_res_id) && $stable(i_res_tag) && $stable(i_res_fired) && $stable(i_res_removed) && $stable(i_res_last), "stalled result changed")

    // expiry reports are always ok and never carry a removal count
    `OTTB_ASSERT_SAME(a_fired_fields, i_res_valid && i_res_fired, i_res_status == ottb_pkg::ST_OK && i_res_removed == 5'd0, "bad expiry result")

    // only expiries come in bursts; every other result is the last one
    `OTTB_ASSERT_SAME(a_single_result, i_res_valid && !i_res_fired, i_res_last, "non-expiry result not last")
endmodule

bind owner_tagged_timer_bank ottb_checker u_ottb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_status  (o_res.result_status),
    .i_res_id      (o_res.result_id),
    .i_res_tag     (o_res.result_tag),
    .i_res_fired   (o_res.fired),
    .i_res_removed (o_res.removed_count),
    .i_res_last    (o_res.last_result)
);

[tb/owner_tagged_timer_bank_tb.sv]
// Self-checking testbench of the owner-tagged timer bank: directed table, then random commands.
`timescale 1ns / 1ps

module owner_tagged_timer_bank_tb;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 310;
    localparam int PAUSE_AT     = 155;
    localparam int DRAIN_CYCLES = (ottb_pkg::SLOTS + 2) * (ottb_pkg::SLOTS + 2);
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  owner;
        logic [15:0] frames;
        logic [15:0] reload;
        logic        periodic;
        logic [15:0] tag;
        logic [31:0] tid;
    } t_timer_cmd;

    typedef struct {
        t_timer_cmd        cmd;
        int                reps;
        bit                typed;
        ottb_pkg::t_result want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ottb_cmd_if cmd_if();
    ottb_res_if res_if();

    owner_tagged_timer_bank i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted timer table
    bit          bank_valid    [ottb_pkg::SLOTS];
    logic [7:0]  bank_owner    [ottb_pkg::SLOTS];
    logic [15:0] bank_left     [ottb_pkg::SLOTS];
    logic [15:0] bank_reload   [ottb_pkg::SLOTS];
    logic        bank_periodic [ottb_pkg::SLOTS];
    logic [31:0] bank_id       [ottb_pkg::SLOTS];
    logic [15:0] bank_tag      [ottb_pkg::SLOTS];
    logic [31:0] id_counter = '0;

    ottb_pkg::t_result pending_results[$];
    t_dir_row          directed_rows[$];
    int                error_count = 0;

    int tx_run = 0;
    bit tx_no_idle = 1'b0;
    int rx_run = 0;
    bit rx_no_idle = 1'b0;

    function automatic ottb_pkg::t_result outcome(input logic [1:0] st, input logic [31:0] id,
                                                  input logic [15:0] tag, input logic fired,
                                                  input logic [4:0] rm, input logic last);
        ottb_pkg::t_result r;
        r.result_status = st;
        r.result_id     = id;
        r.result_tag    = tag;
        r.fired         = fired;
        r.removed_count = rm;
        r.last_result   = last;
        return r;
    endfunction

    function automatic void expect_result(input ottb_pkg::t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic t_timer_cmd mk_cmd(input logic [2:0] act, input logic [7:0] owner,
                                          input logic [15:0] frames, input logic [15:0] reload,
                                          input logic periodic, input logic [15:0] tag,
                                          input logic [31:0] tid);
        t_timer_cmd c;
        c.action   = act;
        c.owner    = owner;
        c.frames   = frames;
        c.reload   = reload;
        c.periodic = periodic;
        c.tag      = tag;
        c.tid      = tid;
        return c;
    endfunction

    function automatic void add_row(input t_timer_cmd c, input int reps, input bit typed,
                                    input ottb_pkg::t_result want);
        t_dir_row r;
        r.cmd   = c;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Applies one command to the predicted table and queues the results it causes.
    function automatic void predict_timers(input t_timer_cmd c);
        int          i;
        int          j;
        int          m;
        int          s;
        int          slot;
        int          hits[$];
        int          n;
        logic [31:0] nid;
        case (c.action)
            ottb_pkg::ACT_CREATE: begin
                nid  = id_counter + 32'd1;
                slot = -1;
                for (i = 0; i < ottb_pkg::SLOTS; i++) begin
                    if (slot < 0 && bank_valid[i] && bank_id[i] == nid) slot = i;
                end
                for (i = 0; i < ottb_pkg::SLOTS; i++) begin
                    if (slot < 0 && !bank_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    expect_result(outcome(ottb_pkg::ST_FULL, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    id_counter          = nid;
                    bank_valid[slot]    = 1'b1;
                    bank_owner[slot]    = c.owner;
                    bank_left[slot]     = c.frames;
                    bank_reload[slot]   = c.reload;
                    bank_periodic[slot] = c.periodic;
                    bank_id[slot]       = nid;
                    bank_tag[slot]      = c.tag;
                    expect_result(outcome(ottb_pkg::ST_OK, nid, '0, 1'b0, '0, 1'b1));
                end
            end
            ottb_pkg::ACT_CANCEL_ID: begin
                slot = -1;
                for (i = 0; i < ottb_pkg::SLOTS; i++) begin
                    if (slot < 0 && bank_valid[i] && bank_id[i] == c.tid) slot = i;
                end
                if (slot < 0) begin
                    expect_result(outcome(ottb_pkg::ST_NOT_FOUND, c.tid, '0, 1'b0, '0, 1'b1));
                end else begin
                    bank_valid[slot] = 1'b0;
                    expect_result(outcome(ottb_pkg::ST_OK, c.tid, bank_tag[slot], 1'b0, '0,
                                          1'b1));
                end
            end
            ottb_pkg::ACT_CANCEL_OWNER, ottb_pkg::ACT_CLEAR_ALL: begin
                n = 0;
                for (i = 0; i < ottb_pkg::SLOTS; i++) begin
                    if (bank_valid[i] && (c.action == ottb_pkg::ACT_CLEAR_ALL ||
                                          bank_owner[i] == c.owner)) begin
                        bank_valid[i] = 1'b0;
                        n++;
                    end
                end
                if (n > 31) n = 31;
                expect_result(outcome(ottb_pkg::ST_OK, '0, '0, 1'b0, 5'(n), 1'b1));
            end
            ottb_pkg::ACT_TICK_OWNER: begin
                for (i = 0; i < ottb_pkg::SLOTS; i++) begin
                    if (bank_valid[i] && bank_owner[i] == c.owner) begin
                        if (bank_left[i] != 16'd0) bank_left[i] = bank_left[i] - 16'd1;
                        if (bank_left[i] == 16'd0) hits.insert(hits.size(), i);
                    end
                end
                if (hits.size() == 0) begin
                    expect_result(outcome(ottb_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    // expiries are reported in ascending id order
                    for (i = 0; i < hits.size() - 1; i++) begin
                        m = i;
                        for (j = i + 1; j < hits.size(); j++) begin
                            if (bank_id[hits[j]] < bank_id[hits[m]]) m = j;
                        end
                        s       = hits[i];
                        hits[i] = hits[m];
                        hits[m] = s;
                    end
                    for (i = 0; i < hits.size(); i++) begin
                        s = hits[i];
                        expect_result(outcome(ottb_pkg::ST_OK, bank_id[s], bank_tag[s], 1'b1,
                                              '0, i == hits.size() - 1));
                        if (bank_periodic[s]) bank_left[s] = bank_reload[s];
                        else bank_valid[s] = 1'b0;
                    end
                end
            end
            default: begin
                expect_result(outcome(ottb_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // Idle cycles for one item; alternates between gappy stretches and back-to-back ones.
    function automatic int idle_draw(inout int run_left, inout bit no_idle);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            no_idle  = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic t_timer_cmd random_cmd();
        t_timer_cmd c;
        int         pick;
        int         idx;
        c.action   = ottb_pkg::ACT_CREATE;
        c.owner    = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        c.frames   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        c.reload   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        c.periodic = 1'($urandom);
        c.tag      = 16'($urandom);
        c.tid      = $urandom;
        pick       = $urandom_range(0, 99);
        if (pick < 30) begin
            c.action = ottb_pkg::ACT_CREATE;
        end else if (pick < 62) begin
            c.action = ottb_pkg::ACT_TICK_OWNER;
        end else if (pick < 78) begin
            c.action = ottb_pkg::ACT_CANCEL_ID;
            if ($urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, ottb_pkg::SLOTS - 1);
                c.tid = bank_valid[idx] ? bank_id[idx] : id_counter - 32'($urandom_range(0, 2));
            end
        end else if (pick < 86) begin
            c.action = ottb_pkg::ACT_CANCEL_OWNER;
        end else if (pick < 90) begin
            c.action = ottb_pkg::ACT_CLEAR_ALL;
        end else if (pick < 94) begin
            c.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end else begin
            // noise: every field drawn over its full range
            c.action = 3'($urandom);
            c.owner  = 8'($urandom);
            c.frames = 16'($urandom);
            c.reload = 16'($urandom);
        end
        return c;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_SHOWN) $display("%s", what);
    endtask

    task automatic send_cmd(input t_timer_cmd c, input bit typed,
                            input ottb_pkg::t_result want);
        int gap;
        gap = idle_draw(tx_run, tx_no_idle);
        if (gap > 0) begin
            @(negedge i_clk) cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.action          <= c.action;
        cmd_if.owner_tag       <= c.owner;
        cmd_if.frames          <= c.frames;
        cmd_if.reload_interval <= c.reload;
        cmd_if.is_periodic     <= c.periodic;
        cmd_if.callback_tag    <= c.tag;
        cmd_if.timer_id        <= c.tid;
        cmd_if.valid           <= 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        predict_timers(c);
        if (typed) pending_results[pending_results.size() - 1] = want;
    endtask

    // drop valid so the last command is not taken again while the sender waits
    task automatic release_cmd();
        @(negedge i_clk) cmd_if.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result receiver with random back-pressure
    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = idle_draw(rx_run, rx_no_idle);
            if (stall > 0) begin
                @(negedge i_clk) res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        ottb_pkg::t_result got;
        ottb_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = outcome(res_if.result_status, res_if.result_id, res_if.result_tag,
                          res_if.fired, res_if.removed_count, res_if.last_result);
            if (pending_results.size() == 0) begin
                flag_error($sformatf({"unexpected result: st=%0d id=%0h tag=%0h fired=%0b",
                                      " rm=%0d last=%0b"},
                                     got.result_status, got.result_id, got.result_tag,
                                     got.fired, got.removed_count, got.last_result));
            end else begin
                want = pending_results.pop_front();
                if (got.result_status !== want.result_status || got.result_id !== want.result_id
                    || got.result_tag !== want.result_tag || got.fired !== want.fired
                    || got.removed_count !== want.removed_count
                    || got.last_result !== want.last_result) begin
                    flag_error($sformatf({"result mismatch: exp st=%0d id=%0h tag=%0h fired=%0b",
                                          " rm=%0d last=%0b / got st=%0d id=%0h tag=%0h",
                                          " fired=%0b rm=%0d last=%0b"},
                                         want.result_status, want.result_id, want.result_tag,
                                         want.fired, want.removed_count, want.last_result,
                                         got.result_status, got.result_id, got.result_tag,
                                         got.fired, got.removed_count, got.last_result));
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        ottb_pkg::t_result none;
        none = '0;
        cmd_if.valid           = 1'b0;
        cmd_if.action          = ottb_pkg::ACT_CREATE;
        cmd_if.owner_tag       = '0;
        cmd_if.frames          = '0;
        cmd_if.reload_interval = '0;
        cmd_if.is_periodic     = 1'b0;
        cmd_if.callback_tag    = '0;
        cmd_if.timer_id        = '0;
        for (int i = 0; i < ottb_pkg::SLOTS; i++) bank_valid[i] = 1'b0;

        // empty table
        add_row(mk_cmd(ottb_pkg::ACT_TICK_OWNER, 8'h00, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_ID, 8'h00, 0, 0, 0, 0, 32'h0), 1, 1'b1,
                outcome(ottb_pkg::ST_NOT_FOUND, 32'h0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_ID, 8'hff, 16'hffff, 16'hffff, 1,
                       16'hffff, 32'hffff_ffff), 1, 1'b1,
                outcome(ottb_pkg::ST_NOT_FOUND, 32'hffff_ffff, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CLEAR_ALL, 8'h00, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_OWNER, 8'hff, 0, 0, 0, 0, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        // zero remaining one-shot expires on the first tick and is gone after
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'h00, 0, 0, 0, 16'ha5a5, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 32'd1, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_TICK_OWNER, 8'h00, 0, 0, 0, 0, 0), 2, 1'b0, none);
        // extremes, and a periodic timer with zero interval
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'hff, 16'hffff, 16'hffff, 1,
                       16'hffff, 32'hffff_ffff), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 32'd2, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'hff, 16'd1, 16'd0, 1, 16'h1234, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 32'd3, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_TICK_OWNER, 8'hff, 0, 0, 0, 0, 0), 2, 1'b0, none);
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_ID, 8'h00, 0, 0, 0, 0, 32'd3), 1, 1'b0, none);
        // fill the table, then one create too many
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'h07, 16'd2, 16'd1, 1, 16'h0f0f, 0),
                ottb_pkg::SLOTS - 1, 1'b0, none);
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'h07, 16'd2, 16'd1, 1, 16'h0f0f, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_FULL, 0, 0, 1'b0, 0, 1'b1));
        // second tick expires every owner-7 timer at once
        add_row(mk_cmd(ottb_pkg::ACT_TICK_OWNER, 8'h07, 0, 0, 0, 0, 0), 2, 1'b0, none);
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_ID, 8'h00, 0, 0, 0, 0, 32'd10), 1, 1'b0, none);
        add_row(mk_cmd(ottb_pkg::ACT_CREATE, 8'h07, 16'd1, 16'd0, 0, 16'h00ff, 0), 1, 1'b0,
                none);
        // reused low slot now holds the highest id
        add_row(mk_cmd(ottb_pkg::ACT_TICK_OWNER, 8'h07, 0, 0, 0, 0, 0), 1, 1'b0, none);
        add_row(mk_cmd(ottb_pkg::ACT_CANCEL_OWNER, 8'h07, 0, 0, 0, 0, 0), 1, 1'b0, none);
        add_row(mk_cmd(ACT_SPARE_FIRST, 8'hff, 16'hffff, 16'hffff, 1,
                       16'hffff, 32'hffff_ffff), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ACT_SPARE_FIRST + 3'd1, 8'h5a, 16'h1, 0, 0, 0, 0), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ACT_SPARE_LAST, 8'h00, 0, 0, 0, 0, 32'd2), 1, 1'b1,
                outcome(ottb_pkg::ST_OK, 0, 0, 1'b0, 0, 1'b1));
        add_row(mk_cmd(ottb_pkg::ACT_CLEAR_ALL, 8'h00, 0, 0, 0, 0, 0), 1, 1'b0, none);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps) begin
                send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
            end
        end
        release_cmd();
        wait_results_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == PAUSE_AT) begin
                release_cmd();
                wait_results_drained();
            end
            send_cmd(random_cmd(), 1'b0, none);
        end
        release_cmd();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
